// ----- sv/mft_pkg.sv -----
// shared types and constants of the motor feedback tracker
package mft_pkg;

    localparam int ENCODER_COUNTS = 8192;
    localparam int ENC_BITS       = $clog2(ENCODER_COUNTS + 1);
    // width of the signed multi-turn count laps * counts + position
    localparam int MW             = 33 + ENC_BITS;
    localparam logic signed [MW-1:0] ENC_S = MW'(ENCODER_COUNTS);

    localparam int TICK_W = 17;
    localparam logic [TICK_W-1:0] TICK_MAX = '1;

    localparam int ADDR_W = 5;
    localparam int DATA_W = 32;

    localparam logic [28:0] RST_MOTOR_ID   = 29'd0;
    localparam logic [15:0] RST_TIMEOUT    = 16'd500;
    localparam logic [14:0] RST_WRAP_TH    = 15'd6000;
    localparam logic [31:0] RST_SPEED_GAIN = 32'd65536;
    localparam logic [31:0] RST_ANGLE_GAIN = 32'd188743680;

    typedef enum logic [2:0] {
        REG_MOTOR_ID   = 3'd0,
        REG_TIMEOUT    = 3'd1,
        REG_WRAP_TH    = 3'd2,
        REG_SPEED_GAIN = 3'd3,
        REG_ANGLE_GAIN = 3'd4
    } t_reg_idx;

    typedef enum logic {
        OP_FRAME = 1'b0,
        OP_TICK  = 1'b1
    } t_op;

    typedef struct packed {
        logic        op;
        logic [28:0] frame_id;
        logic [7:0]  pos_high;
        logic [7:0]  pos_low;
        logic [7:0]  vel_high;
        logic [7:0]  vel_low;
        logic [7:0]  cur_high;
        logic [7:0]  cur_low;
        logic [7:0]  temp_byte;
    } t_in_item;

    typedef struct packed {
        logic               online;
        logic               updated;
        logic signed [15:0] position;
        logic signed [15:0] velocity_raw;
        logic signed [15:0] current;
        logic [7:0]         temperature;
        logic signed [31:0] laps;
        logic signed [31:0] speed_rpm;
        logic signed [47:0] angle_deg;
    } t_out_item;

    // state snapshot carried down the pipeline
    typedef struct packed {
        logic               online;
        logic               updated;
        logic signed [15:0] position;
        logic signed [15:0] velocity_raw;
        logic signed [15:0] current;
        logic [7:0]         temperature;
        logic signed [31:0] laps;
    } t_snap;

endpackage

// ----- sv/mft_if.sv -----
// request and result channels of the motor feedback tracker
interface mft_in_if;
    logic              valid;
    logic              ready;
    mft_pkg::t_in_item payload;
    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

interface mft_out_if;
    logic               valid;
    logic               ready;
    mft_pkg::t_out_item payload;
    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

// ----- sv/motor_feedback_tracker_top.sv -----
// motor feedback tracker: frame unpack, timeout, turn unwrap, speed and angle
// a result passes the request stage and stages 2, 3 and 4, each registered, before it is presented
// throughput: one request per cycle while o_res.ready is high, set by the 4-stage elastic pipeline
// each stage holds one request and moves on when the next one is free
// reset (i_rst_n low at a clock edge) empties the pipeline, restores the
// register defaults and clears online, tick count, positions and turn count
module motor_feedback_tracker_top (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    mft_in_if.sink                         i_req,
    mft_out_if.source                      o_res,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [mft_pkg::ADDR_W-1:0]     paddr,
    input  logic [mft_pkg::DATA_W-1:0]     pwdata,
    output logic [mft_pkg::DATA_W-1:0]     prdata,
    output logic                           pready
);

    // configuration registers
    logic [28:0] r_motor_id;
    logic [15:0] r_timeout;
    logic [14:0] r_wrap_th;
    logic [31:0] r_speed_gain;
    logic [31:0] r_angle_gain;

    // tracked motor state
    logic                              r_online, n_online;
    logic [mft_pkg::TICK_W-1:0]        r_tick, n_tick;
    logic signed [15:0]                r_last_pos, n_last_pos;
    logic signed [31:0]                r_turns, n_turns;
    logic signed [15:0]                r_pos, n_pos;
    logic signed [15:0]                r_vel, n_vel;
    logic signed [15:0]                r_cur, n_cur;
    logic [7:0]                        r_temp, n_temp;
    logic                              n_updated;

    // pipeline valids and per-stage readiness
    logic r_v1, r_v2, r_v3, r_v4;
    logic rdy1, rdy2, rdy3, rdy4;
    logic accept;

    // stage payloads
    mft_pkg::t_snap                    r_s1, r_s2, r_s3;
    logic signed [mft_pkg::MW-1:0]     r_m, n_m;
    logic signed [48:0]                r_prod, n_prod;
    logic [mft_pkg::MW-1:0]            r_a, n_a;
    logic [63:0]                       r_b, n_b;
    logic                              r_neg, n_neg;
    logic signed [31:0]                r_speed, n_speed;
    mft_pkg::t_out_item                r_out, n_out;

    logic                              wr_en;
    mft_pkg::t_reg_idx                 reg_idx;

    // ---------------------------------------------------------------
    // configuration port: zero wait state, write in the access phase
    // ---------------------------------------------------------------
    assign pready  = 1'b1;
    assign wr_en   = psel & penable & pwrite;
    assign reg_idx = mft_pkg::t_reg_idx'(paddr[4:2]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_motor_id   <= mft_pkg::RST_MOTOR_ID;
            r_timeout    <= mft_pkg::RST_TIMEOUT;
            r_wrap_th    <= mft_pkg::RST_WRAP_TH;
            r_speed_gain <= mft_pkg::RST_SPEED_GAIN;
            r_angle_gain <= mft_pkg::RST_ANGLE_GAIN;
        end else if (wr_en) begin
            unique case (reg_idx)
                mft_pkg::REG_MOTOR_ID:   r_motor_id   <= pwdata[28:0];
                mft_pkg::REG_TIMEOUT:    r_timeout    <= pwdata[15:0];
                mft_pkg::REG_WRAP_TH:    r_wrap_th    <= pwdata[14:0];
                mft_pkg::REG_SPEED_GAIN: r_speed_gain <= pwdata;
                mft_pkg::REG_ANGLE_GAIN: r_angle_gain <= pwdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            mft_pkg::REG_MOTOR_ID:   prdata = {3'd0, r_motor_id};
            mft_pkg::REG_TIMEOUT:    prdata = {16'd0, r_timeout};
            mft_pkg::REG_WRAP_TH:    prdata = {17'd0, r_wrap_th};
            mft_pkg::REG_SPEED_GAIN: prdata = r_speed_gain;
            mft_pkg::REG_ANGLE_GAIN: prdata = r_angle_gain;
            default:                 prdata = '0;
        endcase
    end

    // ---------------------------------------------------------------
    // elastic handshake: a stage takes a new request when it is empty
    // or its contents move on in the same cycle
    // ---------------------------------------------------------------
    assign rdy4 = !r_v4 || o_res.ready;
    assign rdy3 = !r_v3 || rdy4;
    assign rdy2 = !r_v2 || rdy3;
    assign rdy1 = !r_v1 || rdy2;

    assign i_req.ready = rdy1;
    assign accept      = i_req.valid && rdy1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else begin
            if (rdy1) r_v1 <= i_req.valid;
            if (rdy2) r_v2 <= r_v1;
            if (rdy3) r_v3 <= r_v2;
            if (rdy4) r_v4 <= r_v3;
        end
    end

    // ---------------------------------------------------------------
    // request stage: tick timeout, frame unpack and turn unwrap
    // ---------------------------------------------------------------
    logic [mft_pkg::TICK_W-1:0] tick_inc;
    logic signed [15:0]         frame_pos;
    logic signed [16:0]         pos_delta;
    logic signed [16:0]         th_pos;
    logic signed [16:0]         th_neg;

    always_comb begin
        n_online   = r_online;
        n_tick     = r_tick;
        n_last_pos = r_last_pos;
        n_turns    = r_turns;
        n_pos      = r_pos;
        n_vel      = r_vel;
        n_cur      = r_cur;
        n_temp     = r_temp;
        n_updated  = 1'b0;

        tick_inc  = (r_tick != mft_pkg::TICK_MAX) ? r_tick + 1'b1 : r_tick;
        frame_pos = {i_req.payload.pos_high, i_req.payload.pos_low};
        // exact difference, one bit wider than the positions
        pos_delta = {frame_pos[15], frame_pos} - {r_last_pos[15], r_last_pos};
        th_pos    = {2'b00, r_wrap_th};
        th_neg    = -th_pos;

        if (accept) begin
            if (i_req.payload.op == mft_pkg::OP_TICK) begin
                n_tick = tick_inc;
                // timeout counts the tick that just arrived
                if (tick_inc > {1'b0, r_timeout}) begin
                    n_online = 1'b0;
                end
            end else if (i_req.payload.frame_id == r_motor_id) begin
                n_updated  = 1'b1;
                n_online   = 1'b1;
                n_tick     = '0;
                n_pos      = frame_pos;
                n_vel      = {i_req.payload.vel_high, i_req.payload.vel_low};
                n_cur      = {i_req.payload.cur_high, i_req.payload.cur_low};
                n_temp     = i_req.payload.temp_byte;
                n_last_pos = frame_pos;
                // large backward jump: crossed zero going forward
                if (pos_delta < th_neg) begin
                    n_turns = r_turns + 32'sd1;
                end else if (pos_delta > th_pos) begin
                    n_turns = r_turns - 32'sd1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_online   <= 1'b0;
            r_tick     <= '0;
            r_last_pos <= '0;
            r_turns    <= '0;
            r_pos      <= '0;
            r_vel      <= '0;
            r_cur      <= '0;
            r_temp     <= '0;
        end else begin
            r_online   <= n_online;
            r_tick     <= n_tick;
            r_last_pos <= n_last_pos;
            r_turns    <= n_turns;
            r_pos      <= n_pos;
            r_vel      <= n_vel;
            r_cur      <= n_cur;
            r_temp     <= n_temp;
        end
    end

    // snapshot of the state after the request
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1.online       <= n_online;
            r_s1.updated      <= n_updated;
            r_s1.position     <= n_pos;
            r_s1.velocity_raw <= n_vel;
            r_s1.current      <= n_cur;
            r_s1.temperature  <= n_temp;
            r_s1.laps         <= n_turns;
        end
    end

    // ---------------------------------------------------------------
    // stage 2: multi-turn count and raw speed product
    // ---------------------------------------------------------------
    always_comb begin
        n_m = mft_pkg::MW'(r_s1.laps) * mft_pkg::ENC_S + mft_pkg::MW'(r_s1.position);
        n_prod = 49'(r_s1.velocity_raw) * $signed({17'd0, r_speed_gain});
    end

    always_ff @(posedge i_clk) begin
        if (rdy2 && r_v1) begin
            r_s2   <= r_s1;
            r_m    <= n_m;
            r_prod <= n_prod;
        end
    end

    // ---------------------------------------------------------------
    // stage 3: magnitude split into two partial products, speed clamp
    // ---------------------------------------------------------------
    logic [mft_pkg::MW-1:0]    m_mag;
    logic [mft_pkg::MW-33:0]   m_hi;
    logic [31:0]               m_lo;

    always_comb begin
        n_neg = r_m[mft_pkg::MW-1];
        m_mag = n_neg ? mft_pkg::MW'(-r_m) : mft_pkg::MW'(r_m);
        m_hi  = m_mag[mft_pkg::MW-1:32];
        m_lo  = m_mag[31:0];
        n_a   = mft_pkg::MW'(m_hi) * mft_pkg::MW'(r_angle_gain);
        n_b   = 64'(m_lo) * 64'(r_angle_gain);

        if (r_prod > 49'sh0_7FFF_FFFF) begin
            n_speed = 32'sh7FFF_FFFF;
        end else if (r_prod < -49'sh0_8000_0000) begin
            n_speed = -32'sh8000_0000;
        end else begin
            n_speed = r_prod[31:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy3 && r_v2) begin
            r_s3    <= r_s2;
            r_a     <= n_a;
            r_b     <= n_b;
            r_neg   <= n_neg;
            r_speed <= n_speed;
        end
    end

    // ---------------------------------------------------------------
    // stage 4: recombine, floor toward minus infinity, saturate
    // ---------------------------------------------------------------
    logic        hi_ovf;
    logic [49:0] q_mag;
    logic        ang_sat;

    always_comb begin
        hi_ovf  = |r_a[mft_pkg::MW-1:32];
        q_mag   = (50'(r_a[31:0]) << 16) + 50'(r_b[63:16])
                + 50'(r_neg && (|r_b[15:0]));
        ang_sat = hi_ovf || (r_neg ? (q_mag > 50'h0_8000_0000_0000)
                                   : (q_mag > 50'h0_7FFF_FFFF_FFFF));

        n_out.online       = r_s3.online;
        n_out.updated      = r_s3.updated;
        n_out.position     = r_s3.position;
        n_out.velocity_raw = r_s3.velocity_raw;
        n_out.current      = r_s3.current;
        n_out.temperature  = r_s3.temperature;
        n_out.laps         = r_s3.laps;
        n_out.speed_rpm    = r_speed;
        if (ang_sat) begin
            n_out.angle_deg = r_neg ? 48'sh8000_0000_0000 : 48'sh7FFF_FFFF_FFFF;
        end else begin
            n_out.angle_deg = r_neg ? -q_mag[47:0] : q_mag[47:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy4 && r_v3) begin
            r_out <= n_out;
        end
    end

    assign o_res.valid   = r_v4;
    assign o_res.payload = r_out;

endmodule
